[sv/stia_pkg.sv]
// Shared types and constants for the any-base string to integer parser.
// No dependencies; compiled first.
`default_nettype none

package stia_pkg;

    localparam int MAX_BASE = 16;
    localparam int NSYM     = 16;
    localparam int BASE_W   = 5;
    localparam int IDX_W    = $clog2(NSYM);
    localparam int VAL_W    = 32;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CTRL_MAX = 8'd31;

    typedef enum logic [1:0] {
        PH_BLANK = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_STOP  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        REG_BASE_LEN = 2'd0,
        REG_SYM_LO   = 2'd1,
        REG_SYM_HI   = 2'd2
    } t_reg_idx;

    typedef logic [NSYM-1:0][7:0] t_symbols;

endpackage

`default_nettype wire

[sv/stia_in_if.sv]
// Character input channel: valid/ready handshake carrying one byte per item.
// Depends on nothing.
`default_nettype none

interface stia_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

[sv/stia_out_if.sv]
// Result channel: valid/ready handshake carrying one signed 32-bit value.
// Depends on nothing.
`default_nettype none

interface stia_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

[sv/stia_alpha.sv]
// Alphabet checker: judges radix and symbol set, purely combinational.
// Depends on stia_pkg.
`default_nettype none

module stia_alpha
    import stia_pkg::*;
(
    input  wire logic [BASE_W-1:0] i_base_len,
    input  wire t_symbols          i_symbols,
    output logic                   o_alpha_ok
);

    always_comb begin
        o_alpha_ok = (i_base_len >= BASE_W'(2)) && (i_base_len <= BASE_W'(MAX_BASE));
        for (int i = 0; i < NSYM; i++) begin
            if (BASE_W'(i) < i_base_len) begin
                if (i_symbols[i] == CH_PLUS || i_symbols[i] == CH_MINUS ||
                    i_symbols[i] <= CTRL_MAX || i_symbols[i][7]) begin
                    o_alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < NSYM; j++) begin
                    if (BASE_W'(j) < i_base_len && i_symbols[j] == i_symbols[i]) begin
                        o_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/string_to_int_any_base.sv]
// Top level of the any-base string to integer parser.
// Depends on stia_pkg, stia_in_if, stia_out_if and stia_alpha.
//
//  channel   dir  handshake        payload
//  i_str     in   valid/ready      ch     [7:0]  unsigned
//  o_res     out  valid/ready      value  [31:0] signed
//  apb       in   psel/penable     base_length @0, symbols_low @8, symbols_high @16
//
// One item per cycle sustained, unless a terminator stalls on a pending result. An item
// sits in the input register, is parsed by one 32x5 multiply-add into the state, and a
// terminator loads the result register, from which o_res presents the value.
// Synchronous active-low reset clears config, parse state and valid flags, not the byte
// and result registers. A pending result stalls only a following terminator; other bytes keep flowing.
`default_nettype none

module string_to_int_any_base
    import stia_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    stia_in_if.sink                i_str,
    stia_out_if.source             o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [BASE_W-1:0] r_base_len;
    logic [63:0]       r_sym_lo;
    logic [63:0]       r_sym_hi;
    t_symbols          symbols;
    logic              alpha_ok;
    t_reg_idx          reg_idx;
    logic              cfg_wr;

    logic              r_in_vld;
    logic [7:0]        r_ch;
    t_phase            r_phase;
    t_phase            n_phase;
    logic              r_neg;
    logic              n_neg;
    logic [VAL_W-1:0]  r_acc;
    logic [VAL_W-1:0]  n_acc;
    logic              r_out_vld;
    logic [VAL_W-1:0]  r_value;
    logic [VAL_W-1:0]  n_value;

    logic              adv;
    logic              is_term;
    logic              is_blank;
    logic              sign_stage;
    logic [BASE_W-1:0] used_len;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [VAL_W-1:0]  mac;

    // configuration
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len <= '0;
            r_sym_lo   <= '0;
            r_sym_hi   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_BASE_LEN: r_base_len <= pwdata[BASE_W-1:0];
                REG_SYM_LO:   r_sym_lo   <= pwdata;
                REG_SYM_HI:   r_sym_hi   <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BASE_LEN: prdata = APB_DW'(r_base_len);
            REG_SYM_LO:   prdata = r_sym_lo;
            REG_SYM_HI:   prdata = r_sym_hi;
            default:      prdata = '0;
        endcase
    end

    assign symbols = t_symbols'({r_sym_hi, r_sym_lo});

    stia_alpha u_alpha (
        .i_base_len (r_base_len),
        .i_symbols  (symbols),
        .o_alpha_ok (alpha_ok)
    );

    // handshake
    assign is_term     = (r_ch == CH_NUL);
    assign adv         = r_in_vld && (!is_term || !r_out_vld || o_res.ready);
    assign i_str.ready = !r_in_vld || adv;
    assign o_res.valid = r_out_vld;
    assign o_res.value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_str.ready) begin
            r_in_vld <= i_str.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_str.ready && i_str.valid) begin
            r_ch <= i_str.ch;
        end
    end

    // digit lookup, lowest position wins
    assign used_len = (r_base_len > BASE_W'(MAX_BASE)) ? BASE_W'(MAX_BASE) : r_base_len;

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NSYM - 1; i >= 0; i--) begin
            if (BASE_W'(i) < used_len && symbols[i] == r_ch) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign mac      = VAL_W'(r_acc * VAL_W'(r_base_len)) + VAL_W'(hit_idx);
    assign is_blank = (r_ch == CH_SPACE) || (r_ch >= CH_TAB && r_ch <= CH_CR);
    assign sign_stage = (r_phase == PH_SIGN) || (r_phase == PH_BLANK && !is_blank);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_value = '0;
        if (is_term) begin
            n_phase = PH_BLANK;
            n_neg   = 1'b0;
            n_acc   = '0;
            if (alpha_ok) begin
                n_value = r_neg ? (VAL_W'(0) - r_acc) : r_acc;
            end
        end else if (r_phase == PH_BLANK && is_blank) begin
            n_phase = PH_BLANK;
        end else if (sign_stage && r_ch == CH_MINUS) begin
            n_phase = PH_SIGN;
            n_neg   = !r_neg;
        end else if (sign_stage && r_ch == CH_PLUS) begin
            n_phase = PH_SIGN;
        end else if (r_phase != PH_STOP) begin
            if (hit) begin
                n_phase = PH_DIGIT;
                n_acc   = mac;
            end else begin
                n_phase = PH_STOP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BLANK;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && is_term) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_term) begin
            r_value <= n_value;
        end
    end

`ifndef SYNTHESIS
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_term) |=> (r_phase == PH_BLANK && !r_neg && r_acc == '0))
        else $error("state not cleared after terminator");

    a_term_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_term) |=> r_out_vld)
        else $error("terminator did not load a result");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_str.ready |-> (r_in_vld && is_term && r_out_vld))
        else $error("input stalled without a pending result");

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOP && adv && !is_term) |=> (r_phase == PH_STOP && $stable(r_acc)))
        else $error("stopped parse changed state");
`endif

endmodule

`default_nettype wire
